// ===== hdl/rpsd_pkg.sv =====
// Shared types and constants for the repeat pattern stuck detector.
// No dependencies; used by every module of the block.
`default_nettype none

package rpsd_pkg;

    localparam int NUM_SENSORS  = 8;
    localparam int READ_W       = 11;
    localparam int FRAME_W      = NUM_SENSORS * READ_W;
    localparam int WEIGHT_W     = 16;
    localparam int TOTAL_W      = 18;
    localparam int SUM_W        = TOTAL_W + 1;
    localparam int THRESH_W     = 16;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [READ_W-1:0]   NO_DETECT    = {READ_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = {WEIGHT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;

    // One classified frame as it sits in the queue.
    typedef struct packed {
        logic               none;
        logic [FRAME_W-1:0] frame;
    } t_item;

    typedef struct packed {
        logic nothing_detected;
        logic seen_before;
        logic stuck;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/rpsd_front.sv =====
// Front end: takes sensor words, clamps readings below -1 and flags all-empty frames.
// Depends on rpsd_pkg.
`default_nettype none

module rpsd_front (
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [rpsd_pkg::FRAME_W-1:0] i_s_tdata,
    output logic                             o_push_valid,
    input  wire logic                        i_push_ready,
    output rpsd_pkg::t_item                  o_push_item
);

    logic [rpsd_pkg::FRAME_W-1:0] clamped;
    logic                         all_none;

    always_comb begin
        logic [rpsd_pkg::READ_W-1:0] v;
        all_none = 1'b1;
        for (int i = 0; i < rpsd_pkg::NUM_SENSORS; i++) begin
            v = i_s_tdata[i*rpsd_pkg::READ_W +: rpsd_pkg::READ_W];
            // negative and not -1: saturate to -1
            if (v[rpsd_pkg::READ_W-1] && (v != rpsd_pkg::NO_DETECT)) begin
                v = rpsd_pkg::NO_DETECT;
            end
            if (v != rpsd_pkg::NO_DETECT) begin
                all_none = 1'b0;
            end
            clamped[i*rpsd_pkg::READ_W +: rpsd_pkg::READ_W] = v;
        end
    end

    assign o_s_tready        = i_push_ready;
    assign o_push_valid      = i_s_tvalid;
    assign o_push_item.none  = all_none;
    assign o_push_item.frame = clamped;

endmodule

`default_nettype wire

// ===== hdl/rpsd_queue.sv =====
// Two-entry queue of classified frames between front and back end.
// Depends on rpsd_pkg.
`default_nettype none

module rpsd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire rpsd_pkg::t_item i_push_item,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output rpsd_pkg::t_item      o_pop_item
);

    rpsd_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rpsd_back.sv =====
// Back end: scans the frame history one entry per cycle, updates weight and score,
// writes the frame into the ring and holds the result word. Depends on rpsd_pkg.
`default_nettype none

module rpsd_back #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [rpsd_pkg::THRESH_W-1:0] i_threshold,
    input  wire logic                          i_pop_valid,
    output logic                               o_pop_ready,
    input  wire rpsd_pkg::t_item               i_pop_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output rpsd_pkg::t_result                  o_out_result
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_EMIT} t_state;

    logic [rpsd_pkg::FRAME_W-1:0] r_hist [HISTORY_DEPTH];
    logic [rpsd_pkg::FRAME_W-1:0] r_rd_data;

    t_state                        r_state;
    logic [rpsd_pkg::FRAME_W-1:0]  r_frame;
    logic                          r_match;
    logic                          r_rd_valid;
    logic [CNT_W-1:0]              r_rd_idx;
    logic [CNT_W-1:0]              r_fill;
    logic [SLOT_W-1:0]             r_slot;
    logic [rpsd_pkg::WEIGHT_W-1:0] r_weight;
    logic [rpsd_pkg::TOTAL_W-1:0]  r_total;
    rpsd_pkg::t_result             r_res;
    rpsd_pkg::t_result             r_out;
    logic                          r_out_valid;

    logic                          scan_issue;
    logic                          hist_we;
    logic [rpsd_pkg::WEIGHT_W-1:0] n_weight;
    logic [rpsd_pkg::TOTAL_W-1:0]  n_total;
    logic [rpsd_pkg::SUM_W-1:0]    sum;
    logic                          over;

    assign scan_issue   = (r_state == S_SCAN) && (r_rd_idx != r_fill);
    assign hist_we      = (r_state == S_UPDATE);
    assign o_pop_ready  = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[r_slot] <= r_frame;
        end
        r_rd_data <= r_hist[r_rd_idx[SLOT_W-1:0]];
    end

    always_comb begin
        sum = '0;
        if (r_match) begin
            n_weight = (r_weight == rpsd_pkg::WEIGHT_MAX) ? r_weight
                     : r_weight + rpsd_pkg::WEIGHT_W'(1);
            sum      = {1'b0, r_total} + rpsd_pkg::SUM_W'(n_weight);
            n_total  = sum[rpsd_pkg::TOTAL_W] ? rpsd_pkg::TOTAL_MAX
                     : sum[rpsd_pkg::TOTAL_W-1:0];
        end else begin
            n_weight = '0;
            n_total  = r_total >> 1;
        end
        over = n_total > rpsd_pkg::TOTAL_W'(i_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_match     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_weight    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= scan_issue;
            // the emit state handles the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_frame  <= i_pop_item.frame;
                        r_match  <= 1'b0;
                        r_rd_idx <= '0;
                        if (i_pop_item.none) begin
                            r_res   <= '{nothing_detected: 1'b1, seen_before: 1'b0,
                                         stuck: 1'b0};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (r_rd_valid && (r_rd_data == r_frame)) begin
                        r_match <= 1'b1;
                    end
                    // last read compared in the previous cycle
                    if (!scan_issue && !r_rd_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (over) begin
                        r_weight <= '0;
                        r_total  <= '0;
                    end else begin
                        r_weight <= n_weight;
                        r_total  <= n_total;
                    end
                    if (r_fill != CNT_W'(HISTORY_DEPTH)) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    if (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                    r_res   <= '{nothing_detected: 1'b0, seen_before: r_match, stuck: over};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/repeat_pattern_stuck_detector.sv =====
// Top level of the repeat pattern stuck detector: threshold register, front end,
// queue and back end. Depends on rpsd_pkg, rpsd_front, rpsd_queue, rpsd_back.
//
// Each word on the slave side is one frame of eight 11-bit sensor readings; one
// result word comes out for every frame. The back end takes a frame whose readings
// are all -1 straight to emit. Any other frame goes through scan, update and emit;
// the scan reads the history RAM, up to 16 stored frames once the ring is full, one
// stored frame per cycle through a single read port and compares each frame against
// the new one. A two-word queue lets the front end take frames while the back end
// is busy, and the result register lets the next frame be scanned while a result
// waits on the master side. The threshold is written via i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle; nothing enforces it.
`default_nettype none

module repeat_pattern_stuck_detector #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rpsd_pkg::THRESH_W-1:0]    i_cfg_wdata,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // sensor_0 [10:0], sensor_1, ... sensor_7 [87:77]
    input  wire logic [rpsd_pkg::FRAME_W-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // stuck [0], seen_before [1], nothing_detected [2], zeros above
    output logic [rpsd_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    logic [rpsd_pkg::THRESH_W-1:0] r_threshold;

    logic              push_valid;
    logic              push_ready;
    rpsd_pkg::t_item   push_item;
    logic              pop_valid;
    logic              pop_ready;
    rpsd_pkg::t_item   pop_item;
    rpsd_pkg::t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= rpsd_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    rpsd_front u_front (
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    rpsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    rpsd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_threshold  (r_threshold),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_item   (pop_item),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_result (out_result)
    );

    assign o_m_tdata = {{(rpsd_pkg::OUT_TDATA_W - 3){1'b0}},
                        out_result.nothing_detected, out_result.seen_before,
                        out_result.stuck};

endmodule

`default_nettype wire
